/* src/cal_pkg.sv */
// Shared types, constants and calendar helper functions for calendar_clock_counter.
// No dependencies; imported by cal_next and calendar_clock_counter.
package cal_pkg;

    // Command codes carried by the cmd field
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // Field limits
    localparam logic [5:0] SEC_MAX   = 6'd59;
    localparam logic [5:0] MIN_MAX   = 6'd59;
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [3:0] MONTH_MAX = 4'd12;

    // Divisibility by 25 on a 16-bit value: multiply by the inverse of 25 mod 2^16
    // and compare against floor((2^16 - 1) / 25).
    localparam logic [15:0] INV25      = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_time;

    localparam t_time TIME_RESET = '{
        year:   16'd2000,
        month:  4'd1,
        day:    5'd1,
        hour:   5'd0,
        minute: 6'd0,
        second: 6'd0
    };

    // Gregorian rule: div by 400 = div by 16 and 25; div by 100 = div by 4 and 25
    function automatic logic is_leap(input logic [15:0] y);
        logic [15:0] prod;
        logic        div4;
        logic        div16;
        logic        div25;
        prod  = y * INV25;
        div4  = (y[1:0] == 2'b00);
        div16 = (y[3:0] == 4'b0000);
        div25 = (prod <= DIV25_LIMIT);
        return div4 && (!div25 || div16);
    endfunction

    // Month length; 0 for a month code outside 1..12
    function automatic logic [4:0] days_in(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* src/cal_next.sv */
// Next-time logic for calendar_clock_counter: one-second carry chain and set check.
// Depends on cal_pkg.
module cal_next
    import cal_pkg::*;
(
    input  logic  i_cmd,
    input  t_time i_cur,
    input  t_time i_set,
    output t_time o_next,
    output logic  o_status
);

    t_time      tick_time;
    logic [4:0] cur_dim;
    logic [4:0] set_dim;
    logic       set_ok;
    logic       c_min;
    logic       c_hour;
    logic       c_day;
    logic       c_month;
    logic       c_year;

    assign cur_dim = days_in(is_leap(i_cur.year), i_cur.month);
    assign set_dim = days_in(is_leap(i_set.year), i_set.month);

    // carry ripple; the >= compares also fold any over-range field back
    always_comb begin
        c_min   = (i_cur.second >= SEC_MAX);
        c_hour  = c_min  && (i_cur.minute >= MIN_MAX);
        c_day   = c_hour && (i_cur.hour >= HOUR_MAX);
        c_month = c_day  && (i_cur.day >= cur_dim);
        c_year  = c_month && (i_cur.month >= MONTH_MAX);

        tick_time.second = c_min   ? 6'd0 : i_cur.second + 6'd1;
        tick_time.minute = c_hour  ? 6'd0 : (c_min   ? i_cur.minute + 6'd1 : i_cur.minute);
        tick_time.hour   = c_day   ? 5'd0 : (c_hour  ? i_cur.hour + 5'd1   : i_cur.hour);
        tick_time.day    = c_month ? 5'd1 : (c_day   ? i_cur.day + 5'd1    : i_cur.day);
        tick_time.month  = c_year  ? 4'd1 : (c_month ? i_cur.month + 4'd1  : i_cur.month);
        tick_time.year   = c_year  ? i_cur.year + 16'd1 : i_cur.year;
    end

    // set_dim is 0 for an illegal month, so the day compare rejects it too
    assign set_ok = (i_set.hour <= HOUR_MAX) && (i_set.minute <= MIN_MAX)
                 && (i_set.second <= SEC_MAX) && (i_set.day != 5'd0)
                 && (i_set.day <= set_dim);

    always_comb begin
        unique case (i_cmd)
            CMD_TICK: begin
                o_next   = tick_time;
                o_status = 1'b0;
            end
            CMD_SET: begin
                o_next   = set_ok ? i_set : i_cur;
                o_status = !set_ok;
            end
            default: begin
                o_next   = i_cur;
                o_status = 1'b0;
            end
        endcase
    end

endmodule

/* src/calendar_clock_counter.sv */
// Top level of the real-time clock calendar: input register, time state, result register.
// Depends on cal_pkg and cal_next.
//
// Usage:
//   Input channel (i_valid / o_stall): a word is a command, either a one-second
//   tick (i_cmd = CMD_TICK) or a date/time set (i_cmd = CMD_SET) with the new
//   fields. Output channel (o_valid / i_stall): one word per input, the time
//   after that command and o_status (1 when a set was illegal and ignored).
//   An accepted word sits in the input register until it can advance, then
//   the time state and the result register update together.
//   Throughput is one word per cycle while the receiver does not stall; the
//   leap-year check (one 16-bit constant multiply per year checked) and the
//   carry chain fit in that single stage.
//   When the receiver stalls, the result register holds its word, the input
//   register keeps one more, and o_stall rises only when both are full.
//   Synchronous active-low reset empties both registers and sets the time to
//   2000-01-01 00:00:00.
module calendar_clock_counter
    import cal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [15:0] i_new_year,
    input  logic [3:0]  i_new_month,
    input  logic [4:0]  i_new_day,
    input  logic [4:0]  i_new_hour,
    input  logic [5:0]  i_new_minute,
    input  logic [5:0]  i_new_second,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_cur_year,
    output logic [3:0]  o_cur_month,
    output logic [4:0]  o_cur_day,
    output logic [4:0]  o_cur_hour,
    output logic [5:0]  o_cur_minute,
    output logic [5:0]  o_cur_second,
    output logic        o_status
);

    logic  r_in_valid;
    logic  r_in_cmd;
    t_time r_in_set;
    t_time r_time;
    logic  r_out_valid;
    t_time r_out_time;
    logic  r_out_status;

    t_time n_time;
    logic  n_status;
    logic  advance;
    logic  take;

    // word moves from the input register into the result register
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign take    = i_valid && !o_stall;
    assign o_stall = r_in_valid && !advance;

    cal_next u_next (
        .i_cmd    (r_in_cmd),
        .i_cur    (r_time),
        .i_set    (r_in_set),
        .o_next   (n_time),
        .o_status (n_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_time      <= TIME_RESET;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_time      <= n_time;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_cmd        <= i_cmd;
            r_in_set.year   <= i_new_year;
            r_in_set.month  <= i_new_month;
            r_in_set.day    <= i_new_day;
            r_in_set.hour   <= i_new_hour;
            r_in_set.minute <= i_new_minute;
            r_in_set.second <= i_new_second;
        end
        if (advance) begin
            r_out_time   <= n_time;
            r_out_status <= n_status;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cur_year   = r_out_time.year;
    assign o_cur_month  = r_out_time.month;
    assign o_cur_day    = r_out_time.day;
    assign o_cur_hour   = r_out_time.hour;
    assign o_cur_minute = r_out_time.minute;
    assign o_cur_second = r_out_time.second;
    assign o_status     = r_out_status;

endmodule
